FILE: rtl/core/tkspq_pkg.sv
// ---------------------------------------------------------------------------
// tkspq_pkg
// Shared types and codes for the two-key sorted priority queue.
// ---------------------------------------------------------------------------
package tkspq_pkg;

  localparam int DEPTH_DEF        = 16;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int KEY_BITS         = 32;

  localparam logic       OP_PUSH = 1'b0;
  localparam logic       OP_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic        op;
    logic [15:0] primary_key;
    logic [15:0] secondary_key;
    logic [31:0] payload;
  } tkspq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_primary;
    logic [15:0] out_secondary;
    logic [31:0] out_payload;
    logic [4:0]  occupancy;
  } tkspq_out_t;

  typedef struct packed {
    logic                push;
    logic                pop;
    logic [KEY_BITS-1:0] new_key;
  } tkspq_cmd_t;

endpackage

FILE: rtl/core/two_key_sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// two_key_sorted_priority_queue
// Bounded priority queue ordered by primary then secondary key.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) carries push or pop items; every
// item gives exactly one result on the output channel (out_valid/out_ready/
// out_data) with a status and the occupancy after the item.
// Entries sit in a row of DEPTH cells kept sorted; a push compares all cells
// at once and shifts the tail by one, a pop shifts every cell toward the
// head. Equal key pairs leave in arrival order.
// The result is registered and offered in the cycle after the transfer.
// Throughput: one item per cycle while the receiver does not stall, set by
// the cell compare and shift. A push on a full queue is refused (full
// status), a pop on an empty queue returns empty status with zero fields.
// Reset empties the queue (count to zero) and drops any pending result.
// When the receiver stalls, the result register holds and in_ready drops
// until the result transfers.
// ---------------------------------------------------------------------------
module two_key_sorted_priority_queue #(
  parameter int DEPTH        = tkspq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = tkspq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tkspq_pkg::tkspq_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tkspq_pkg::tkspq_out_t out_data
);
  import tkspq_pkg::*;

  localparam int EW = KEY_BITS + PAYLOAD_BITS;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           out_valid_r;
  logic           out_valid_nxt;
  tkspq_out_t     out_r;
  tkspq_out_t     out_nxt;

  logic           accept;
  logic           full;
  logic           empty;
  tkspq_cmd_t     cmd;
  logic [EW-1:0]  new_entry;
  logic [EW-1:0]  cell_entry [DEPTH];
  logic           cell_keep  [DEPTH];
  logic [31:0]    occ_ext;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign new_entry = {in_data.primary_key, in_data.secondary_key,
                      in_data.payload[PAYLOAD_BITS-1:0]};

  assign cmd.push    = accept && (in_data.op == OP_PUSH) && !full;
  assign cmd.pop     = accept && (in_data.op == OP_POP) && !empty;
  assign cmd.new_key = {in_data.primary_key, in_data.secondary_key};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          left_keep;
    logic [EW-1:0] left_entry;
    logic [EW-1:0] right_entry;

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_keep  = cell_keep[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    tkspq_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (count_r > CW'(i)),
      .left_keep   (left_keep),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign occ_ext = 32'(count_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (accept) begin
      out_valid_nxt         = 1'b1;
      out_nxt.status        = STATUS_OK;
      out_nxt.out_primary   = '0;
      out_nxt.out_secondary = '0;
      out_nxt.out_payload   = '0;
      out_nxt.occupancy     = occ_ext[4:0];
      if (in_data.op == OP_PUSH) begin
        if (full) begin
          out_nxt.status = STATUS_FULL;
        end
      end else if (empty) begin
        out_nxt.status = STATUS_EMPTY;
      end else begin
        out_nxt.out_primary   = cell_entry[0][EW-1 -: 16];
        out_nxt.out_secondary = cell_entry[0][EW-17 -: 16];
        out_nxt.out_payload   = 32'(cell_entry[0][PAYLOAD_BITS-1:0]);
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/tkspq_cell.sv
// ---------------------------------------------------------------------------
// tkspq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// incoming key and shifts toward the tail on push or the head on pop.
// ---------------------------------------------------------------------------
module tkspq_cell #(
  parameter int PAYLOAD_BITS = tkspq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                                        clk,
  input  tkspq_pkg::tkspq_cmd_t                       cmd,
  input  logic                                        occ,
  input  logic                                        left_keep,
  input  logic [tkspq_pkg::KEY_BITS+PAYLOAD_BITS-1:0] new_entry,
  input  logic [tkspq_pkg::KEY_BITS+PAYLOAD_BITS-1:0] left_entry,
  input  logic [tkspq_pkg::KEY_BITS+PAYLOAD_BITS-1:0] right_entry,
  output logic [tkspq_pkg::KEY_BITS+PAYLOAD_BITS-1:0] entry,
  output logic                                        keep
);
  import tkspq_pkg::*;

  localparam int EW = KEY_BITS + PAYLOAD_BITS;

  logic [EW-1:0] entry_r;
  logic [EW-1:0] entry_nxt;

  assign keep  = occ && (entry_r[EW-1 -: KEY_BITS] <= cmd.new_key);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.push) begin
      if (!keep) begin
        entry_nxt = left_keep ? new_entry : left_entry;
      end
    end else if (cmd.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

FILE: tb/sv/two_key_sorted_priority_queue_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// two_key_sorted_priority_queue_tb
// Drives push and pop transfers into the two-key sorted priority queue and
// checks every result against a software copy of the queue: sorted order by
// primary then secondary key, arrival order among equal key pairs, full and
// empty status, and occupancy. Both channels idle at random, the receiver
// holds off for a long stretch once, and the sender waits for every result
// to drain between some phases.
// ---------------------------------------------------------------------------
module two_key_sorted_priority_queue_tb;
  import tkspq_pkg::*;

  localparam int QUEUE_DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RX_HOLD     = 200;

  typedef struct packed {
    logic [15:0] pkey;
    logic [15:0] skey;
    logic [31:0] data;
  } qentry_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  tkspq_in_t  in_data;
  logic       out_valid;
  logic       out_ready;
  tkspq_out_t out_data;

  qentry_t    held_entries[$];
  tkspq_out_t predicted_results[$];
  int         mismatch_count;
  int         cycle_count;
  int         tx_mode;
  int         rx_mode;
  int         rx_hold_cycles;

  two_key_sorted_priority_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mode 0: no idling, 1: uniform, 2: mostly back to back
  function automatic int draw_wait(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 12);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    endcase
  endfunction

  function automatic logic [15:0] rand_key();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3));
      1: return 16'(16'hFFFF - $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tkspq_in_t make_item(input logic op, input logic [15:0] pk,
                                          input logic [15:0] sk, input logic [31:0] pl);
    tkspq_in_t item;
    item.op            = op;
    item.primary_key   = pk;
    item.secondary_key = sk;
    item.payload       = pl;
    return item;
  endfunction

  function automatic tkspq_out_t predict_queue_op(input tkspq_in_t item);
    tkspq_out_t res;
    qentry_t    ent;
    int         pos;
    res = '0;
    if (item.op == OP_PUSH) begin
      if (held_entries.size() >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        ent = '{item.primary_key, item.secondary_key, item.payload};
        pos = 0;
        while (pos < held_entries.size() &&
               {held_entries[pos].pkey, held_entries[pos].skey} <= {ent.pkey, ent.skey})
          pos++;
        held_entries.insert(pos, ent);
        res.status = STATUS_OK;
      end
    end else if (held_entries.size() == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      ent = held_entries.pop_front();
      res.status        = STATUS_OK;
      res.out_primary   = ent.pkey;
      res.out_secondary = ent.skey;
      res.out_payload   = ent.data;
    end
    res.occupancy = 5'(held_entries.size());
    return res;
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  task automatic send_item(input tkspq_in_t item);
    int gap;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted_results.push_back(predict_queue_op(item));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_traffic(input int n, input int push_pct, input int tx, input int rx);
    logic op;
    tx_mode = tx;
    rx_mode = rx;
    repeat (n) begin
      op = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP;
      send_item(make_item(op, rand_key(), rand_key(), $urandom));
    end
  endtask

  task automatic test_pop_empty();
    send_item(make_item(OP_POP, 16'h0000, 16'h0000, 32'h0000_0000));
    send_item(make_item(OP_POP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_fill_and_full();
    logic [15:0] pk;
    logic [15:0] sk;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      case (i % 3)
        0: pk = 16'h8000;
        1: pk = 16'h0000;
        default: pk = 16'hFFFF;
      endcase
      sk = ((i / 3) % 2 == 0) ? 16'h0000 : 16'hFFFF;
      send_item(make_item(OP_PUSH, pk, sk, i[0] ? (32'hFFFF_FFFF ^ i) : 32'(i)));
    end
    send_item(make_item(OP_PUSH, 16'h0000, 16'h0000, 32'hDEAD_BEEF));
    send_item(make_item(OP_PUSH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_pop_order_and_tie();
    repeat (3) send_item(make_item(OP_POP, 16'h1234, 16'h5678, 32'h0));
    send_item(make_item(OP_PUSH, 16'h0000, 16'h0000, 32'h5A5A_5A5A));
  endtask

  task automatic test_receiver_hold();
    wait_drained();
    tx_mode = 0;
    rx_hold_cycles = RX_HOLD;
    repeat (20) begin
      send_item(make_item(($urandom_range(0, 9) < 7) ? OP_PUSH : OP_POP,
                          rand_key(), rand_key(), $urandom));
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    mismatch_count = 0;
    tx_mode        = 1;
    rx_mode        = 1;
    rx_hold_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pop_empty();
    test_fill_and_full();
    test_pop_order_and_tie();

    run_traffic(60, 70, 1, 1);
    run_traffic(60, 30, 0, 0);
    wait_drained();
    run_traffic(60, 80, 2, 1);
    run_traffic(60, 20, 1, 2);
    test_receiver_hold();
    run_traffic(60, 60, 2, 0);
    wait_drained();
    run_traffic(60, 40, 0, 1);
    run_traffic(60, 75, 1, 0);
    run_traffic(60, 25, 2, 2);
    run_traffic(40, 50, 1, 1);

    wait_drained();
    repeat (4) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $error("%0d results never arrived", predicted_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = draw_wait(rx_mode);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    tkspq_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        $error("result transfer with no item outstanding: %h", out_data);
        mismatch_count++;
      end else begin
        exp_r = predicted_results.pop_front();
        check_field("status", 32'(exp_r.status), 32'(out_data.status));
        check_field("out_primary", 32'(exp_r.out_primary), 32'(out_data.out_primary));
        check_field("out_secondary", 32'(exp_r.out_secondary), 32'(out_data.out_secondary));
        check_field("out_payload", exp_r.out_payload, out_data.out_payload);
        check_field("occupancy", 32'(exp_r.occupancy), 32'(out_data.occupancy));
      end
    end
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

FILE: filelist.f
rtl/core/tkspq_pkg.sv
rtl/core/tkspq_cell.sv
rtl/core/two_key_sorted_priority_queue.sv
tb/sv/two_key_sorted_priority_queue_tb.sv
